// ===== sv/firmware_upload_sender_assert.svh =====
// assertion macros for the checker file
`ifndef FIRMWARE_UPLOAD_SENDER_ASSERT_SVH
`define FIRMWARE_UPLOAD_SENDER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define FUS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("firmware_upload_sender: check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define FUS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("firmware_upload_sender: check failed");

`endif

// ===== sv/fus_pkg.sv =====
`default_nettype none

package fus_pkg;

	// item taken in: start request or one timer tick with an optional reply
	typedef struct packed {
		logic       action;
		logic       reply_valid;
		logic [7:0] reply_status;
	} in_item_t;

	// item given out: report to send plus upload status
	typedef struct packed {
		logic        send_valid;
		logic [7:0]  report_code;
		logic [15:0] report_word;
		logic [7:0]  payload_length;
		logic [1:0]  status;
	} out_item_t;

	// action codes
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_TICK  = 1'b1;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_SIZE       = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_CHECKSUM   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_ACK_VALUE        = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_REPORT_CODE = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_DATA_REPORT_CODE = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_SUM_REPORT_CODE  = 3'd5;

	// sequencer phases
	localparam logic [3:0] PH_IDLE     = 4'd0;
	localparam logic [3:0] PH_SIZE     = 4'd1;
	localparam logic [3:0] PH_SIZE_ACK = 4'd2;
	localparam logic [3:0] PH_DATA     = 4'd3;
	localparam logic [3:0] PH_DATA_ACK = 4'd4;
	localparam logic [3:0] PH_SUM      = 4'd5;
	localparam logic [3:0] PH_SUM_ACK  = 4'd6;
	localparam logic [3:0] PH_VER      = 4'd7;
	localparam logic [3:0] PH_DONE     = 4'd8;
	localparam logic [3:0] PH_FAIL     = 4'd9;

	// status codes
	localparam logic [1:0] ST_BUSY   = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_DONE   = 2'd2;
	localparam logic [1:0] ST_FAILED = 2'd3;

	// limits
	localparam logic [15:0] PACKET_MAX      = 16'd60;
	localparam logic [9:0]  SIZE_WAIT_LIMIT = 10'd1000;
	localparam logic [9:0]  ACK_WAIT_LIMIT  = 10'd50;
	localparam logic [3:0]  RETRY_LIMIT     = 4'd10;

	// reset values of the configuration registers
	localparam logic [7:0] ACK_VALUE_RST        = 8'd1;
	localparam logic [7:0] SIZE_REPORT_CODE_RST = 8'd1;
	localparam logic [7:0] DATA_REPORT_CODE_RST = 8'd2;
	localparam logic [7:0] SUM_REPORT_CODE_RST  = 8'd3;

endpackage

`default_nettype wire

// ===== sv/firmware_upload_sender.sv =====
// firmware upload sender: an accepted item is registered in stage 1, its result in the result register
// throughput one item per cycle while the output is not stalled; the limit is the sequencer update in stage 2
// stage 1 registers the incoming item, stage 2 updates state and loads the result register
// arst_n low: pipeline empty, phase idle, counters and offsets zero,
// configuration registers at their defaults (ack 1, report codes 1/2/3, size and sum 0)
`default_nettype none

module firmware_upload_sender (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration write port
	input  wire logic                             cfg_wr_en,
	input  wire logic [fus_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [15:0]                      cfg_data,
	// input channel
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire fus_pkg::in_item_t                in_item,
	// output channel
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output fus_pkg::out_item_t                    out_item
);

	// configuration registers
	logic [15:0] image_size_q;
	logic [15:0] image_checksum_q;
	logic [7:0]  ack_value_q;
	logic [7:0]  size_report_code_q;
	logic [7:0]  data_report_code_q;
	logic [7:0]  sum_report_code_q;

	// sequencer state
	logic [3:0]  phase_q;
	logic [15:0] bytes_left_q;
	logic [15:0] packet_offset_q;
	logic [9:0]  wait_ticks_q;
	logic [3:0]  retry_count_q;

	// stage 1: registered input item
	logic               valid_s1;
	fus_pkg::in_item_t  item_s1;

	// result register
	logic               out_valid_q;
	fus_pkg::out_item_t out_item_q;

	// next-state and result of the item in stage 1
	logic [3:0]  phase_d;
	logic [15:0] bytes_left_d;
	logic [15:0] packet_offset_d;
	logic [9:0]  wait_ticks_d;
	logic [3:0]  retry_count_d;
	fus_pkg::out_item_t res;

	// timeout bookkeeping shared by the data, checksum and version waits
	logic [9:0]  wt_inc;
	logic [3:0]  rc_inc;
	logic        wt_expired;
	logic        rc_exhausted;

	// size-ack wait counter path
	logic [9:0]  size_wt_base;
	logic [9:0]  size_wt_inc;

	logic        is_ack;
	logic        out_free;
	logic        adv_s1;

	// result register can take a new item when empty or being drained
	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && out_free;
	// stage 1 only holds when its item cannot move on
	assign in_stall = valid_s1 && !out_free;

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// configuration writes, index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q       <= '0;
			image_checksum_q   <= '0;
			ack_value_q        <= fus_pkg::ACK_VALUE_RST;
			size_report_code_q <= fus_pkg::SIZE_REPORT_CODE_RST;
			data_report_code_q <= fus_pkg::DATA_REPORT_CODE_RST;
			sum_report_code_q  <= fus_pkg::SUM_REPORT_CODE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				fus_pkg::CFG_IMAGE_SIZE:       image_size_q       <= cfg_data;
				fus_pkg::CFG_IMAGE_CHECKSUM:   image_checksum_q   <= cfg_data;
				fus_pkg::CFG_ACK_VALUE:        ack_value_q        <= cfg_data[7:0];
				fus_pkg::CFG_SIZE_REPORT_CODE: size_report_code_q <= cfg_data[7:0];
				fus_pkg::CFG_DATA_REPORT_CODE: data_report_code_q <= cfg_data[7:0];
				fus_pkg::CFG_SUM_REPORT_CODE:  sum_report_code_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// stage 1 payload, no reset needed
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_item;
		end
	end

	assign is_ack = (item_s1.reply_status == ack_value_q);

	// generic wait-tick timeout: counts a tick, on expiry counts a retry
	assign wt_inc       = wait_ticks_q + 10'd1;
	assign wt_expired   = (wt_inc > fus_pkg::ACK_WAIT_LIMIT);
	assign rc_inc       = retry_count_q + 4'd1;
	assign rc_exhausted = (rc_inc >= fus_pkg::RETRY_LIMIT);

	// size-ack wait: a reply restarts the count, this tick still counts
	assign size_wt_base = item_s1.reply_valid ? 10'd0 : wait_ticks_q;
	assign size_wt_inc  = size_wt_base + 10'd1;

	// sequencer step for the item in stage 1
	always_comb begin
		phase_d            = phase_q;
		bytes_left_d       = bytes_left_q;
		packet_offset_d    = packet_offset_q;
		wait_ticks_d       = wait_ticks_q;
		retry_count_d      = retry_count_q;
		res.send_valid     = 1'b0;
		res.report_code    = '0;
		res.report_word    = '0;
		res.payload_length = '0;

		if (item_s1.action == fus_pkg::ACT_START) begin
			// restart from the size report; wait and retry counts carry over
			bytes_left_d    = image_size_q;
			packet_offset_d = '0;
			phase_d         = fus_pkg::PH_SIZE;
		end else begin
			case (phase_q)
				fus_pkg::PH_SIZE: begin
					res.send_valid  = 1'b1;
					res.report_code = size_report_code_q;
					res.report_word = image_size_q;
					wait_ticks_d    = '0;
					phase_d         = fus_pkg::PH_SIZE_ACK;
				end
				fus_pkg::PH_SIZE_ACK: begin
					if (item_s1.reply_valid && is_ack) begin
						retry_count_d = '0;
						phase_d       = fus_pkg::PH_DATA;
					end
					// timeout here only restarts the wait
					wait_ticks_d = (size_wt_inc > fus_pkg::SIZE_WAIT_LIMIT) ? 10'd0 : size_wt_inc;
				end
				fus_pkg::PH_DATA: begin
					res.send_valid  = 1'b1;
					res.report_code = data_report_code_q;
					res.report_word = packet_offset_q;
					res.payload_length = (bytes_left_q > fus_pkg::PACKET_MAX) ?
						fus_pkg::PACKET_MAX[7:0] : bytes_left_q[7:0];
					phase_d         = fus_pkg::PH_DATA_ACK;
				end
				fus_pkg::PH_DATA_ACK: begin
					if (item_s1.reply_valid) begin
						// a non-ack reply is ignored; an ack keeps wait_ticks as is
						if (is_ack) begin
							if (bytes_left_q > fus_pkg::PACKET_MAX) begin
								bytes_left_d    = bytes_left_q - fus_pkg::PACKET_MAX;
								packet_offset_d = packet_offset_q + fus_pkg::PACKET_MAX;
								phase_d         = fus_pkg::PH_DATA;
							end else begin
								bytes_left_d    = '0;
								packet_offset_d = '0;
								phase_d         = fus_pkg::PH_SUM;
							end
						end
					end else if (wt_expired) begin
						wait_ticks_d  = '0;
						retry_count_d = rc_exhausted ? 4'd0 : rc_inc;
						phase_d       = rc_exhausted ? fus_pkg::PH_FAIL : fus_pkg::PH_DATA;
					end else begin
						wait_ticks_d = wt_inc;
					end
				end
				fus_pkg::PH_SUM: begin
					res.send_valid  = 1'b1;
					res.report_code = sum_report_code_q;
					res.report_word = image_checksum_q;
					wait_ticks_d    = '0;
					retry_count_d   = '0;
					phase_d         = fus_pkg::PH_SUM_ACK;
				end
				fus_pkg::PH_SUM_ACK: begin
					if (item_s1.reply_valid) begin
						// any reply other than ack fails the upload here
						if (is_ack) begin
							wait_ticks_d  = '0;
							retry_count_d = '0;
							phase_d       = fus_pkg::PH_VER;
						end else begin
							phase_d = fus_pkg::PH_FAIL;
						end
					end else if (wt_expired) begin
						wait_ticks_d  = '0;
						retry_count_d = rc_exhausted ? 4'd0 : rc_inc;
						phase_d       = rc_exhausted ? fus_pkg::PH_FAIL : fus_pkg::PH_SUM;
					end else begin
						wait_ticks_d = wt_inc;
					end
				end
				fus_pkg::PH_VER: begin
					if (item_s1.reply_valid && is_ack) begin
						phase_d = fus_pkg::PH_DONE;
					end else if (wt_expired) begin
						// timeout counts a retry but resends nothing
						wait_ticks_d  = '0;
						retry_count_d = rc_exhausted ? 4'd0 : rc_inc;
						phase_d       = rc_exhausted ? fus_pkg::PH_FAIL : fus_pkg::PH_VER;
					end else begin
						wait_ticks_d = wt_inc;
					end
				end
				// idle, done, failed and unused codes ignore ticks
				default: ;
			endcase
		end

		// status reflects the phase after this item
		case (phase_d)
			fus_pkg::PH_DONE: res.status = fus_pkg::ST_DONE;
			fus_pkg::PH_FAIL: res.status = fus_pkg::ST_FAILED;
			fus_pkg::PH_SIZE, fus_pkg::PH_SIZE_ACK, fus_pkg::PH_DATA, fus_pkg::PH_DATA_ACK,
			fus_pkg::PH_SUM, fus_pkg::PH_SUM_ACK, fus_pkg::PH_VER: res.status = fus_pkg::ST_BUSY;
			default: res.status = fus_pkg::ST_IDLE;
		endcase
	end

	// stage 2: sequencer state, updated once per item that moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= fus_pkg::PH_IDLE;
			bytes_left_q    <= '0;
			packet_offset_q <= '0;
			wait_ticks_q    <= '0;
			retry_count_q   <= '0;
		end else if (adv_s1) begin
			phase_q         <= phase_d;
			bytes_left_q    <= bytes_left_d;
			packet_offset_q <= packet_offset_d;
			wait_ticks_q    <= wait_ticks_d;
			retry_count_q   <= retry_count_d;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_item_q <= res;
		end
	end

endmodule

`default_nettype wire

// ===== sv/fus_checker.sv =====
`default_nettype none

`include "firmware_upload_sender_assert.svh"

module fus_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire fus_pkg::out_item_t out_item
);

	// a stalled result item stays put
	`FUS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))

	// no report means all report fields are zero
	`FUS_ASSERT_IMP(a_no_send_zero, out_valid && !out_item.send_valid, out_item.report_code == 8'd0 && out_item.report_word == 16'd0 && out_item.payload_length == 8'd0)

	// packet length only on a sent report and never above the packet limit
	`FUS_ASSERT_IMP(a_len_bound, out_valid && out_item.payload_length != 8'd0, out_item.send_valid && {8'd0, out_item.payload_length} <= fus_pkg::PACKET_MAX)

	// every report leaves the sequencer waiting, so status is busy
	`FUS_ASSERT_IMP(a_send_busy, out_valid && out_item.send_valid, out_item.status == fus_pkg::ST_BUSY)

endmodule

bind firmware_upload_sender fus_checker u_fus_checker (.*);

`default_nettype wire

// ===== test/firmware_upload_sender_tb.sv =====
`timescale 1ns / 1ps

module firmware_upload_sender_tb;
	import fus_pkg::*;

	// spare register indexes past the last real register, writes there are dropped
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned SWEEP_RUNS     = 5;
	localparam int unsigned ITEMS_PER_RUN  = 25;
	localparam int unsigned MAX_REPORTS    = 10;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [15:0]            cfg_data  = '0;
	logic                   in_valid  = 1'b0;
	logic                   in_stall;
	in_item_t               in_item   = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	out_item_t              out_item;

	// items waiting to be driven, and the reports the sequencer owes us
	in_item_t  queued_actions[$];
	out_item_t pending_reports[$];

	// shadow copy of the configuration registers, at their reset values
	logic [15:0] cfg_size  = '0;
	logic [15:0] cfg_sum   = '0;
	logic [7:0]  cfg_ack   = ACK_VALUE_RST;
	logic [7:0]  code_size = SIZE_REPORT_CODE_RST;
	logic [7:0]  code_data = DATA_REPORT_CODE_RST;
	logic [7:0]  code_sum  = SUM_REPORT_CODE_RST;

	// shadow copy of the sequencer state
	logic [3:0]  ph         = PH_IDLE;
	logic [15:0] left_bytes = '0;
	logic [15:0] offset     = '0;
	logic [9:0]  waited     = '0;
	logic [3:0]  retries    = '0;

	// bookkeeping
	int unsigned items_sent      = 0;
	int unsigned items_queued    = 0;
	int unsigned reports_checked = 0;
	int unsigned mismatches      = 0;
	int unsigned uploads_done    = 0;
	int unsigned uploads_failed  = 0;
	int unsigned settings_used   = 0;
	int unsigned send_gap        = 0;
	int unsigned stall_left      = 0;
	int unsigned idle_cycles     = 0;
	int unsigned cycle_count     = 0;
	bit          send_calm       = 1'b0;
	bit          recv_calm       = 1'b0;

	firmware_upload_sender dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// sequencer prediction
	// ------------------------------------------------------------------

	// one tick of an acknowledge wait; on overflow either retry or give up
	function automatic void bump_timeout(logic [3:0] resend);
		waited = waited + 10'd1;
		if (waited > ACK_WAIT_LIMIT) begin
			waited  = '0;
			retries = retries + 4'd1;
			if (retries >= RETRY_LIMIT) begin
				retries = '0;
				ph      = PH_FAIL;
			end else begin
				ph = resend;
			end
		end
	endfunction

	// advance the shadow sequencer by one item and return the report it gives
	function automatic out_item_t sequencer_step(in_item_t it);
		out_item_t  r;
		logic       acked;
		logic [3:0] prior;
		r     = '0;
		prior = ph;
		acked = (it.reply_status == cfg_ack);
		if (it.action == ACT_START) begin
			// restart from the size report, counters are left alone
			left_bytes = cfg_size;
			offset     = '0;
			ph         = PH_SIZE;
		end else begin
			case (ph)
				PH_SIZE: begin
					r.send_valid  = 1'b1;
					r.report_code = code_size;
					r.report_word = cfg_size;
					waited        = '0;
					ph            = PH_SIZE_ACK;
				end
				PH_SIZE_ACK: begin
					// any reply restarts the wait, the tick itself still counts
					if (it.reply_valid) begin
						waited = '0;
						if (acked) begin
							retries = '0;
							ph      = PH_DATA;
						end
					end
					waited = waited + 10'd1;
					// size wait overflow only rewaits
					if (waited > SIZE_WAIT_LIMIT)
						waited = '0;
				end
				PH_DATA: begin
					r.send_valid     = 1'b1;
					r.report_code    = code_data;
					r.report_word    = offset;
					r.payload_length = (left_bytes > PACKET_MAX) ? 8'(PACKET_MAX)
						: 8'(left_bytes);
					ph               = PH_DATA_ACK;
				end
				PH_DATA_ACK: begin
					// data ack keeps the running wait count
					if (it.reply_valid) begin
						if (acked) begin
							if (left_bytes > PACKET_MAX) begin
								left_bytes = left_bytes - PACKET_MAX;
								offset     = offset + PACKET_MAX;
								ph         = PH_DATA;
							end else begin
								left_bytes = '0;
								offset     = '0;
								ph         = PH_SUM;
							end
						end
					end else begin
						bump_timeout(PH_DATA);
					end
				end
				PH_SUM: begin
					r.send_valid  = 1'b1;
					r.report_code = code_sum;
					r.report_word = cfg_sum;
					waited        = '0;
					retries       = '0;
					ph            = PH_SUM_ACK;
				end
				PH_SUM_ACK: begin
					// a wrong status here ends the upload
					if (it.reply_valid) begin
						if (acked) begin
							waited  = '0;
							retries = '0;
							ph      = PH_VER;
						end else begin
							ph = PH_FAIL;
						end
					end else begin
						bump_timeout(PH_SUM);
					end
				end
				PH_VER: begin
					// timeout here counts a retry without resending
					if (it.reply_valid && acked)
						ph = PH_DONE;
					else
						bump_timeout(PH_VER);
				end
				default: begin
				end
			endcase
		end

		if (ph != prior && ph == PH_DONE)
			uploads_done++;
		if (ph != prior && ph == PH_FAIL)
			uploads_failed++;

		if (ph == PH_DONE)
			r.status = ST_DONE;
		else if (ph == PH_FAIL)
			r.status = ST_FAILED;
		else if (ph >= PH_SIZE && ph <= PH_VER)
			r.status = ST_BUSY;
		else
			r.status = ST_IDLE;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------

	function automatic void check_report(out_item_t got);
		out_item_t want;
		if (pending_reports.size() == 0) begin
			if (mismatches < MAX_REPORTS)
				$display("%0t: report with nothing outstanding: send=%0d code=%0h word=%0h len=%0d st=%0d",
					$realtime, got.send_valid, got.report_code, got.report_word,
					got.payload_length, got.status);
			mismatches++;
			return;
		end
		want = pending_reports.pop_front();
		reports_checked++;
		if (got.send_valid !== want.send_valid || got.report_code !== want.report_code
				|| got.report_word !== want.report_word
				|| got.payload_length !== want.payload_length
				|| got.status !== want.status) begin
			if (mismatches < MAX_REPORTS) begin
				$display("%0t: report %0d differs", $realtime, reports_checked);
				$display("  wanted send=%0d code=%0h word=%0h len=%0d st=%0d",
					want.send_valid, want.report_code, want.report_word,
					want.payload_length, want.status);
				$display("  got    send=%0d code=%0h word=%0h len=%0d st=%0d",
					got.send_valid, got.report_code, got.report_word,
					got.payload_length, got.status);
			end
			mismatches++;
		end
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int unsigned pick_pause(bit calm);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ------------------------------------------------------------------
	// input driver
	// ------------------------------------------------------------------

	always @(posedge clk) begin : drive_items
		logic fire;
		fire = in_valid && !in_stall;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (fire) begin
				pending_reports.push_back(sequencer_step(in_item));
				items_sent++;
				// switch between gap-free stretches and gappy ones
				if (items_sent % 128 == 0)
					send_calm = ($urandom_range(0, 2) == 0);
				send_gap = pick_pause(send_calm);
			end else if (!in_valid && send_gap != 0) begin
				send_gap--;
			end
			// load the next item only when the current one is gone
			if ((fire || !in_valid) && send_gap == 0 && queued_actions.size() != 0) begin
				in_item  <= queued_actions.pop_front();
				in_valid <= 1'b1;
			end else if (fire) begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// output monitor with random back-pressure
	// ------------------------------------------------------------------

	always @(posedge clk) begin : watch_reports
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			cycle_count++;
			if (out_valid && !out_stall)
				check_report(out_item);
			if (cycle_count % 150 == 0)
				recv_calm = ($urandom_range(0, 2) == 0);
			if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall  <= 1'b0;
				stall_left = pick_pause(recv_calm);
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog: too long without any item moving on either side
	// ------------------------------------------------------------------

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles, %0d reports outstanding",
					$realtime, idle_cycles, pending_reports.size());
				$display("firmware_upload_sender_tb: done, errors");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	task automatic queue_item(logic action, logic reply_valid, logic [7:0] reply_status);
		in_item_t it;
		it.action       = action;
		it.reply_valid  = reply_valid;
		it.reply_status = reply_status;
		queued_actions.push_back(it);
		items_queued++;
	endtask

	function automatic logic [7:0] non_ack();
		logic [7:0] s;
		s = 8'($urandom);
		if (s == cfg_ack)
			s = ~s;
		return s;
	endfunction

	task automatic ack_tick();
		queue_item(ACT_TICK, 1'b1, cfg_ack);
	endtask

	// tick in a sending phase, where any reply is ignored
	task automatic send_tick();
		queue_item(ACT_TICK, 1'($urandom), 8'($urandom));
	endtask

	// ticks with no acknowledge; with replies on, some carry a wrong status
	task automatic quiet_ticks(int unsigned n, bit replies);
		for (int unsigned i = 0; i < n; i++) begin
			if (replies && $urandom_range(0, 2) == 0)
				queue_item(ACT_TICK, 1'b1, non_ack());
			else
				queue_item(ACT_TICK, 1'b0, 8'($urandom));
		end
	endtask

	function automatic int unsigned noise_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 12);
	endfunction

	// one upload from start to version ack, possibly cut short by the next start
	task automatic queue_upload(int unsigned max_packets);
		int unsigned packets;
		int unsigned cap;
		packets = (int'(cfg_size) + int'(PACKET_MAX) - 1) / int'(PACKET_MAX);
		if (packets == 0)
			packets = 1;
		cap = (packets < max_packets) ? packets : max_packets;
		if ($urandom_range(0, 7) == 0)
			cap = $urandom_range(1, cap);

		queue_item(ACT_START, 1'($urandom), 8'($urandom));
		send_tick();
		quiet_ticks(noise_len(), 1'b1);
		ack_tick();
		for (int unsigned p = 0; p < cap; p++) begin
			send_tick();
			quiet_ticks(noise_len(), 1'b1);
			ack_tick();
		end
		if (cap < packets)
			return;

		send_tick();
		quiet_ticks(noise_len(), 1'b0);
		if ($urandom_range(0, 19) == 0) begin
			// bad checksum reply
			queue_item(ACT_TICK, 1'b1, non_ack());
			quiet_ticks(2, 1'b1);
			return;
		end
		ack_tick();
		quiet_ticks(noise_len(), 1'b0);
		// sometimes restart while the version ack is still outstanding
		if ($urandom_range(0, 9) == 0)
			return;
		ack_tick();
		quiet_ticks($urandom_range(0, 2), 1'b1);
	endtask

	task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [15:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			CFG_IMAGE_SIZE:       cfg_size  = value;
			CFG_IMAGE_CHECKSUM:   cfg_sum   = value;
			CFG_ACK_VALUE:        cfg_ack   = value[7:0];
			CFG_SIZE_REPORT_CODE: code_size = value[7:0];
			CFG_DATA_REPORT_CODE: code_data = value[7:0];
			CFG_SUM_REPORT_CODE:  code_sum  = value[7:0];
			default: begin
			end
		endcase
	endtask

	// all registers in one go; junk in the upper byte of the narrow ones must be dropped
	task automatic apply_settings(logic [15:0] size, logic [15:0] sum, logic [7:0] ack,
			logic [7:0] c_size, logic [7:0] c_data, logic [7:0] c_sum);
		cfg_write(CFG_IMAGE_SIZE, size);
		cfg_write(CFG_IMAGE_CHECKSUM, sum);
		cfg_write(CFG_ACK_VALUE, {8'($urandom), ack});
		cfg_write(CFG_SIZE_REPORT_CODE, {8'($urandom), c_size});
		cfg_write(CFG_DATA_REPORT_CODE, {8'($urandom), c_data});
		cfg_write(CFG_SUM_REPORT_CODE, {8'($urandom), c_sum});
		if ($urandom_range(0, 1) == 0)
			cfg_write(CFG_SPARE_LO, 16'($urandom));
		else
			cfg_write(CFG_SPARE_HI, 16'($urandom));
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	// wait until every queued item went in and every report came back
	task automatic drain();
		do
			@(posedge clk);
		while (queued_actions.size() != 0 || in_valid || pending_reports.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pass at reset defaults: empty image, ack status 1
		queue_item(ACT_TICK, 1'b1, 8'hFF);   // tick while idle does nothing
		queue_item(ACT_START, 1'b1, 8'h00);
		queue_item(ACT_TICK, 1'b0, 8'h00);   // size report
		queue_item(ACT_TICK, 1'b1, 8'h00);   // wrong status in size wait only restarts the wait
		ack_tick();
		queue_item(ACT_TICK, 1'b0, 8'h00);   // empty image gives one zero-length packet
		queue_item(ACT_TICK, 1'b1, 8'hAA);   // wrong status in data wait is ignored
		queue_item(ACT_TICK, 1'b0, 8'h00);
		ack_tick();
		send_tick();                         // checksum report
		ack_tick();
		queue_item(ACT_TICK, 1'b1, 8'h55);   // version wait: wrong status just counts
		ack_tick();                          // done
		ack_tick();                          // ticks after done do nothing
		queue_item(ACT_START, 1'b0, 8'hFF);
		send_tick();
		ack_tick();
		send_tick();
		ack_tick();
		send_tick();
		queue_item(ACT_TICK, 1'b1, 8'hFE);   // bad checksum reply fails the upload
		ack_tick();                          // nothing happens once failed
		queue_item(ACT_START, 1'b1, 8'h01);  // start from failed
		send_tick();
		queue_item(ACT_START, 1'b0, 8'h00);  // start in the middle of a sequence
		drain();

		// sweep of register settings, extremes first
		for (int unsigned run = 0; run < SWEEP_RUNS; run++) begin
			int unsigned max_packets;
			int unsigned start_count;
			max_packets = 1000;
			case (run)
				0: apply_settings(16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00);
				1: begin
					// full-size image: only a few packets per upload, then restart
					apply_settings(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
					max_packets = 4;
				end
				2: apply_settings(16'(PACKET_MAX), 16'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom), 8'($urandom));
				3: apply_settings(16'(PACKET_MAX) + 16'd1, 16'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom), 8'($urandom));
				default: apply_settings(16'($urandom_range(0, 400)), 16'($urandom),
					8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
			endcase
			start_count = items_queued;
			while (items_queued - start_count < ITEMS_PER_RUN)
				queue_upload(max_packets);
			drain();
		end

		// long waits: data retries running out, then a checksum resend
		// and a version retry before the upload completes
		apply_settings(16'd45, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom));
		queue_item(ACT_START, 1'b0, 8'h00);
		send_tick();
		ack_tick();
		send_tick();
		quiet_ticks(540, 1'b0);
		send_tick();

		queue_item(ACT_START, 1'b0, 8'h00);
		send_tick();
		ack_tick();
		send_tick();
		ack_tick();
		send_tick();
		quiet_ticks(int'(ACK_WAIT_LIMIT) + 10, 1'b0);
		ack_tick();
		quiet_ticks(int'(ACK_WAIT_LIMIT) + 10, 1'b1);
		ack_tick();
		ack_tick();
		drain();

		repeat (8) @(posedge clk);
		$display("drove %0d items over %0d register settings, checked %0d reports",
			items_sent, settings_used, reports_checked);
		$display("uploads completed %0d, failed %0d, mismatches %0d",
			uploads_done, uploads_failed, mismatches);
		if (mismatches == 0 && pending_reports.size() == 0)
			$display("firmware_upload_sender_tb: done, clean");
		else
			$display("firmware_upload_sender_tb: done, errors");
		$finish;
	end

endmodule
